// ===== rtl/hsv_to_rgb_pixel_converter_defines.svh =====
// Assertion macros for the HSV to RGB pixel converter.
// Included by the top level; no dependencies.
`ifndef HSV_TO_RGB_PIXEL_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define HSV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HSV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hsv_pkg.sv =====
// Shared types and constants for the HSV to RGB pixel converter.
// No dependencies; compiled first.
package hsv_pkg;

    // Hue handling
    localparam logic [8:0]  HUE_MAX     = 9'd359;
    localparam logic [5:0]  SECTOR_SPAN = 6'd60;
    localparam int          NUM_SECTORS = 6;

    // Scale constants: full scale and sector span times full scale
    localparam logic [7:0]  FULL_SCALE  = 8'd255;
    localparam logic [13:0] SPAN_SCALE  = 14'd15300;

    // Reciprocals for the constant divisions: floor(2^SHIFT / divisor)
    localparam int          SHIFT_P     = 24;
    localparam logic [16:0] RECIP_P     = 17'd65793;
    localparam int          SHIFT_Q     = 32;
    localparam logic [18:0] RECIP_Q     = 19'd280716;

    // Intermediate widths
    localparam int          NUM_W       = 14;
    localparam int          XP_W        = 16;
    localparam int          XQ_W        = 22;

    // Register stages from input to output
    localparam logic [2:0]  PIPE_DEPTH  = 3'd6;

    // Hue sectors
    localparam logic [2:0]  SEC_RED_YEL = 3'd0;
    localparam logic [2:0]  SEC_YEL_GRN = 3'd1;
    localparam logic [2:0]  SEC_GRN_CYN = 3'd2;
    localparam logic [2:0]  SEC_CYN_BLU = 3'd3;
    localparam logic [2:0]  SEC_BLU_MAG = 3'd4;
    localparam logic [2:0]  SEC_MAG_RED = 3'd5;

    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_out;

    // After sector split
    typedef struct packed {
        logic [2:0] sector;
        logic [5:0] rem;
        logic [7:0] sat;
        logic [7:0] bri;
    } t_sec;

    // Numerators of p, q and t
    typedef struct packed {
        logic [2:0]       sector;
        logic [7:0]       bri;
        logic [7:0]       np;
        logic [NUM_W-1:0] nq;
        logic [NUM_W-1:0] nt;
    } t_num;

    // Full products before division
    typedef struct packed {
        logic [2:0]      sector;
        logic [7:0]      bri;
        logic [XP_W-1:0] xp;
        logic [XQ_W-1:0] xq;
        logic [XQ_W-1:0] xt;
    } t_prod;

    // Quotient estimates, possibly one low
    typedef struct packed {
        logic [2:0]      sector;
        logic [7:0]      bri;
        logic [XP_W-1:0] xp;
        logic [XQ_W-1:0] xq;
        logic [XQ_W-1:0] xt;
        logic [7:0]      p0;
        logic [7:0]      q0;
        logic [7:0]      t0;
    } t_est;

    // Exact channel candidates
    typedef struct packed {
        logic [2:0] sector;
        logic [7:0] bri;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } t_pqt;

endpackage

// ===== rtl/hsv_stream_if.sv =====
// Valid/ready stream interface used on both pixel channels.
// The payload type is set per instance; no package dependency.
interface hsv_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hsv_sector.sv =====
// Stage 1: hue clamp and split into sector and remainder.
// Depends on hsv_pkg.
module hsv_sector import hsv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_pix_in i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_sec    o_data
);

    logic [8:0] hue_c;
    logic [2:0] sec;
    t_sec       n_data;
    logic       r_valid;
    t_sec       r_data;

    // Clamp, then find the sector by threshold compares
    always_comb begin
        hue_c = (i_data.hue > HUE_MAX) ? HUE_MAX : i_data.hue;
        sec   = 3'd0;
        for (int k = 1; k < NUM_SECTORS; k++) begin
            if (hue_c >= 9'(k * SECTOR_SPAN)) begin
                sec = 3'(k);
            end
        end
        n_data.sector = sec;
        n_data.rem    = 6'(hue_c - 9'(sec) * 9'(SECTOR_SPAN));
        n_data.sat    = i_data.saturation;
        n_data.bri    = i_data.brightness;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/hsv_mix.sv =====
// Stages 2 and 3: numerators of p, q, t, then their products with value.
// Depends on hsv_pkg.
module hsv_mix import hsv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_sec  i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_prod o_data
);

    t_num       n_num;
    t_prod      n_prod;
    logic       r_num_valid;
    t_num       r_num;
    logic       r_prod_valid;
    t_prod      r_prod;
    logic       num_ready;
    logic [5:0] rem_c;

    // Stage 2: s*rem and s*(60-rem) taken from the span scale
    always_comb begin
        rem_c         = SECTOR_SPAN - i_data.rem;
        n_num.sector  = i_data.sector;
        n_num.bri     = i_data.bri;
        n_num.np      = FULL_SCALE - i_data.sat;
        n_num.nq      = SPAN_SCALE - NUM_W'(i_data.sat) * NUM_W'(i_data.rem);
        n_num.nt      = SPAN_SCALE - NUM_W'(i_data.sat) * NUM_W'(rem_c);
    end

    // Stage 3: products with value
    always_comb begin
        n_prod.sector = r_num.sector;
        n_prod.bri    = r_num.bri;
        n_prod.xp     = XP_W'(r_num.bri) * XP_W'(r_num.np);
        n_prod.xq     = XQ_W'(r_num.bri) * XQ_W'(r_num.nq);
        n_prod.xt     = XQ_W'(r_num.bri) * XQ_W'(r_num.nt);
    end

    assign num_ready = !r_prod_valid || i_ready;
    assign o_ready   = !r_num_valid || num_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_valid  <= 1'b0;
            r_prod_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_num_valid <= i_valid;
            end
            if (num_ready) begin
                r_prod_valid <= r_num_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_num <= n_num;
        end
        if (num_ready && r_num_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_prod_valid;
    assign o_data  = r_prod;

endmodule

// ===== rtl/hsv_div.sv =====
// Stages 4 and 5: division by 255 and 15300 via reciprocal multiply,
// then one compare-and-increment correction. Depends on hsv_pkg.
module hsv_div import hsv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_prod i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_pqt  o_data
);

    localparam int EP_W = XP_W + 17;
    localparam int EQ_W = XQ_W + 19;

    logic [EP_W-1:0] ep;
    logic [EQ_W-1:0] eq;
    logic [EQ_W-1:0] et;
    logic [XP_W-1:0] rp;
    logic [XQ_W-1:0] rq;
    logic [XQ_W-1:0] rt;
    t_est            n_est;
    t_pqt            n_pqt;
    logic            r_est_valid;
    t_est            r_est;
    logic            r_pqt_valid;
    t_pqt            r_pqt;
    logic            est_ready;

    // Stage 4: estimates, never above the true quotient and at most one below
    always_comb begin
        ep           = EP_W'(i_data.xp) * EP_W'(RECIP_P);
        eq           = EQ_W'(i_data.xq) * EQ_W'(RECIP_Q);
        et           = EQ_W'(i_data.xt) * EQ_W'(RECIP_Q);
        n_est.sector = i_data.sector;
        n_est.bri    = i_data.bri;
        n_est.xp     = i_data.xp;
        n_est.xq     = i_data.xq;
        n_est.xt     = i_data.xt;
        n_est.p0     = ep[SHIFT_P +: 8];
        n_est.q0     = eq[SHIFT_Q +: 8];
        n_est.t0     = et[SHIFT_Q +: 8];
    end

    // Stage 5: remainder check, bump the estimate when a divisor is left over
    always_comb begin
        rp           = r_est.xp - XP_W'(r_est.p0) * XP_W'(FULL_SCALE);
        rq           = r_est.xq - XQ_W'(r_est.q0) * XQ_W'(SPAN_SCALE);
        rt           = r_est.xt - XQ_W'(r_est.t0) * XQ_W'(SPAN_SCALE);
        n_pqt.sector = r_est.sector;
        n_pqt.bri    = r_est.bri;
        n_pqt.p      = (rp >= XP_W'(FULL_SCALE)) ? r_est.p0 + 8'd1 : r_est.p0;
        n_pqt.q      = (rq >= XQ_W'(SPAN_SCALE)) ? r_est.q0 + 8'd1 : r_est.q0;
        n_pqt.t      = (rt >= XQ_W'(SPAN_SCALE)) ? r_est.t0 + 8'd1 : r_est.t0;
    end

    assign est_ready = !r_pqt_valid || i_ready;
    assign o_ready   = !r_est_valid || est_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est_valid <= 1'b0;
            r_pqt_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_est_valid <= i_valid;
            end
            if (est_ready) begin
                r_pqt_valid <= r_est_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_est <= n_est;
        end
        if (est_ready && r_est_valid) begin
            r_pqt <= n_pqt;
        end
    end

    assign o_valid = r_pqt_valid;
    assign o_data  = r_pqt;

endmodule

// ===== rtl/hsv_route.sv =====
// Stage 6: sector mux onto red, green and blue; output register.
// Depends on hsv_pkg.
module hsv_route import hsv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_pqt     i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_pix_out o_data
);

    t_pix_out n_data;
    logic     r_valid;
    t_pix_out r_data;

    // Six-way channel assignment
    always_comb begin
        unique case (i_data.sector)
            SEC_RED_YEL: begin
                n_data = '{red: i_data.bri, green: i_data.t, blue: i_data.p};
            end
            SEC_YEL_GRN: begin
                n_data = '{red: i_data.q, green: i_data.bri, blue: i_data.p};
            end
            SEC_GRN_CYN: begin
                n_data = '{red: i_data.p, green: i_data.bri, blue: i_data.t};
            end
            SEC_CYN_BLU: begin
                n_data = '{red: i_data.p, green: i_data.q, blue: i_data.bri};
            end
            SEC_BLU_MAG: begin
                n_data = '{red: i_data.t, green: i_data.p, blue: i_data.bri};
            end
            default: begin
                n_data = '{red: i_data.bri, green: i_data.p, blue: i_data.q};
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/hsv_to_rgb_pixel_converter.sv =====
// HSV to RGB pixel converter: takes one pixel item per clock and returns one
// RGB item per clock while the output is not stalled, through six register
// stages (sector split, numerators, products, reciprocal estimate,
// correction, channel mux). Every stage has its own valid bit and is
// refilled as soon as its successor can take its item, so bubbles close up
// and a stall on the output holds items without loss. Divisions by 255 and
// 15300 are exact: a reciprocal multiply followed by one correction step.
// Hue above 359 is treated as 359. No configuration and no state.
// Depends on hsv_pkg, hsv_stream_if and the stage modules.
`include "hsv_to_rgb_pixel_converter_defines.svh"

module hsv_to_rgb_pixel_converter import hsv_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsv_stream_if.sink    i_pix,
    hsv_stream_if.source  o_pix
);

    logic     sec_valid;
    logic     sec_ready;
    t_sec     sec_data;
    logic     mix_valid;
    logic     mix_ready;
    t_prod    mix_data;
    logic     div_valid;
    logic     div_ready;
    t_pqt     div_data;
    logic     rt_ready;
    t_pix_out rt_data;
    logic     rt_valid;

    // Pipeline
    hsv_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (sec_ready),
        .i_data  (i_pix.data),
        .o_valid (sec_valid),
        .i_ready (mix_ready),
        .o_data  (sec_data)
    );

    hsv_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sec_valid),
        .o_ready (mix_ready),
        .i_data  (sec_data),
        .o_valid (mix_valid),
        .i_ready (div_ready),
        .o_data  (mix_data)
    );

    hsv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .o_ready (div_ready),
        .i_data  (mix_data),
        .o_valid (div_valid),
        .i_ready (rt_ready),
        .o_data  (div_data)
    );

    hsv_route u_route (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (rt_ready),
        .i_data  (div_data),
        .o_valid (rt_valid),
        .i_ready (o_pix.ready),
        .o_data  (rt_data)
    );

    assign i_pix.ready = sec_ready;
    assign o_pix.valid = rt_valid;
    assign o_pix.data  = rt_data;

    // Items in flight, for the checks below
    logic       in_acc;
    logic       out_acc;
    logic [2:0] r_occ;
    logic [2:0] n_occ;

    assign in_acc  = i_pix.valid && i_pix.ready;
    assign out_acc = o_pix.valid && o_pix.ready;
    assign n_occ   = r_occ + 3'(in_acc) - 3'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 3'd0;
        end else begin
            r_occ <= n_occ;
        end
    end

    `HSV_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= PIPE_DEPTH, "pipe over-full")
    `HSV_ASSERT_IMP(a_out_backed, i_clk, i_rst_n, o_pix.valid, r_occ != 3'd0, "item invented")
    `HSV_ASSERT_IMP(a_no_block, i_clk, i_rst_n, !o_pix.valid, i_pix.ready, "input blocked")
    `HSV_ASSERT_NXT(a_drain, i_clk, i_rst_n, out_acc && !in_acc && r_occ == 3'd1, !o_pix.valid, "item repeated")

endmodule

// ===== dv/hsv_to_rgb_pixel_converter_tb.sv =====
// Self-checking testbench for the HSV to RGB pixel converter.
// Needs hsv_pkg, hsv_stream_if and the converter RTL; runs on its own.
module hsv_to_rgb_pixel_converter_tb;
    import hsv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;

    hsv_stream_if #(.T(t_pix_in))  pix_in_if ();
    hsv_stream_if #(.T(t_pix_out)) pix_out_if ();

    hsv_to_rgb_pixel_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in_if),
        .o_pix   (pix_out_if)
    );

    t_pix_out rgb_expected_q[$];
    t_pix_out rgb_want;
    int       mismatch_count = 0;
    bit       send_gaps_on   = 1'b0;
    bit       recv_gaps_on   = 1'b0;
    int       hold_request   = 0;
    int       hold_left      = 0;

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Expected colour for one pixel, exact integer division throughout
    function automatic t_pix_out expected_rgb(t_pix_in px);
        logic [31:0] h, s, v, rem, p, q, t;
        logic [2:0]  sector;
        t_pix_out    rgb;
        h = (px.hue > HUE_MAX) ? 32'(HUE_MAX) : 32'(px.hue);
        s = 32'(px.saturation);
        v = 32'(px.brightness);
        sector = 3'(h / SECTOR_SPAN);
        rem    = h % SECTOR_SPAN;
        p = (v * (FULL_SCALE - s)) / FULL_SCALE;
        q = (v * (SPAN_SCALE - s * rem)) / SPAN_SCALE;
        t = (v * (SPAN_SCALE - s * (SECTOR_SPAN - rem))) / SPAN_SCALE;
        case (sector)
            SEC_RED_YEL: rgb = '{v[7:0], t[7:0], p[7:0]};
            SEC_YEL_GRN: rgb = '{q[7:0], v[7:0], p[7:0]};
            SEC_GRN_CYN: rgb = '{p[7:0], v[7:0], t[7:0]};
            SEC_CYN_BLU: rgb = '{p[7:0], q[7:0], v[7:0]};
            SEC_BLU_MAG: rgb = '{t[7:0], p[7:0], v[7:0]};
            default:     rgb = '{v[7:0], p[7:0], q[7:0]}; // magenta to red
        endcase
        return rgb;
    endfunction

    // Output ready: random gaps, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            pix_out_if.ready <= 1'b0;
        end else begin
            pix_out_if.ready <= recv_gaps_on ? ($urandom_range(99) >= 37) : 1'b1;
        end
    end

    // Predict on each accepted pixel, check each accepted colour
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_in_if.valid && pix_in_if.ready)
                rgb_expected_q.push_back(expected_rgb(pix_in_if.data));
            if (pix_out_if.valid && pix_out_if.ready) begin
                if (rgb_expected_q.size() == 0) begin
                    $error("unexpected colour item: %0d %0d %0d", pix_out_if.data.red,
                           pix_out_if.data.green, pix_out_if.data.blue);
                    mismatch_count++;
                end else begin
                    rgb_want = rgb_expected_q.pop_front();
                    if (pix_out_if.data.red !== rgb_want.red) begin
                        $error("red: expected %0d, got %0d", rgb_want.red,
                               pix_out_if.data.red);
                        mismatch_count++;
                    end
                    if (pix_out_if.data.green !== rgb_want.green) begin
                        $error("green: expected %0d, got %0d", rgb_want.green,
                               pix_out_if.data.green);
                        mismatch_count++;
                    end
                    if (pix_out_if.data.blue !== rgb_want.blue) begin
                        $error("blue: expected %0d, got %0d", rgb_want.blue,
                               pix_out_if.data.blue);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Offer one pixel, with optional idle cycles first, until it is taken
    task automatic send_pixel(input logic [8:0] hue, input logic [7:0] sat,
                              input logic [7:0] bri);
        if (send_gaps_on) begin
            while ($urandom_range(99) < 37) begin
                pix_in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        pix_in_if.valid <= 1'b1;
        pix_in_if.data  <= t_pix_in'{hue, sat, bri};
        do @(posedge i_clk); while (!pix_in_if.ready);
    endtask

    // Mostly legal hues, some above range; extremes of s and v now and then
    task automatic send_random_pixel();
        logic [8:0] hue;
        logic [7:0] sat, bri;
        hue = ($urandom_range(9) == 0) ? 9'($urandom_range(511, 360))
                                       : 9'($urandom_range(359, 0));
        case ($urandom_range(9))
            0:       sat = 8'd0;
            1:       sat = 8'd255;
            default: sat = 8'($urandom_range(255));
        endcase
        case ($urandom_range(9))
            0:       bri = 8'd0;
            1:       bri = 8'd255;
            default: bri = 8'($urandom_range(255));
        endcase
        send_pixel(hue, sat, bri);
    endtask

    // Sector boundaries, hue above range, zero saturation, zero brightness
    task automatic test_directed();
        int unsigned sector_hues[14] = '{0, 59, 60, 119, 120, 179, 180, 239,
                                         240, 299, 300, 359, 360, 511};
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        foreach (sector_hues[i])
            send_pixel(9'(sector_hues[i]), 8'd255, 8'd255);
        send_pixel(9'd200, 8'd0,   8'd200);
        send_pixel(9'd511, 8'd0,   8'd255);
        send_pixel(9'd100, 8'd255, 8'd0);
        send_pixel(9'd0,   8'd0,   8'd0);
        send_pixel(9'd45,  8'd128, 8'd77);
        send_pixel(9'd300, 8'd1,   8'd1);
        send_pixel(9'd30,  8'd254, 8'd254);
        send_pixel(9'd256, 8'd170, 8'd85);
    endtask

    // Back-to-back pixels, output always ready
    task automatic test_random_stream(input int count);
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
        repeat (count) send_random_pixel();
    endtask

    // Random gaps on both sides
    task automatic test_random_gaps(input int count);
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        repeat (count) send_random_pixel();
    endtask

    // Output held off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure(input int count);
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b1;
        hold_request = 150;
        repeat (count) send_random_pixel();
    endtask

    // Let every expected colour arrive, then idle on before the final check
    task automatic drain_pipeline();
        int guard;
        guard = 0;
        pix_in_if.valid <= 1'b0;
        while (rgb_expected_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);
        if (rgb_expected_q.size() != 0) begin
            $error("%0d colour items never arrived", rgb_expected_q.size());
            mismatch_count++;
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        pix_in_if.valid  = 1'b0;
        pix_in_if.data   = '0;
        pix_out_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_stream(400);
        test_backpressure(50);
        test_random_gaps(1080);
        drain_pipeline();

        if (mismatch_count == 0 && rgb_expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_600_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== hsv_to_rgb_pixel_converter.f =====
+incdir+rtl
rtl/hsv_pkg.sv
rtl/hsv_stream_if.sv
rtl/hsv_sector.sv
rtl/hsv_mix.sv
rtl/hsv_div.sv
rtl/hsv_route.sv
rtl/hsv_to_rgb_pixel_converter.sv
dv/hsv_to_rgb_pixel_converter_tb.sv
